// File: src/tctm_pkg.sv
// Shared types, codes and helpers of the transposed-convolution tile MAC.
package tctm_pkg;

	// Fixed field widths of the stream words, the result limit and the bias shift.
	localparam int VALUE_W = 16;
	localparam int SUM_W = 32;
	localparam int CHAN_W = 4;
	localparam int RESULT_LIMIT = 16;
	localparam int CFG_W = 5;
	localparam int FRAC_SHIFT = 12;

	// Operation codes carried in the input tuser.
	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_TILE   = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_IN_CHANNELS  = 1'b0,
		REG_OUT_CHANNELS = 1'b1
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_RUN,
		ST_DRAIN
	} seq_state_t;

	// One multiply-accumulate beat travelling beside the memory read data.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic              term;
		logic              last_chan;
		logic [CHAN_W-1:0] chan;
	} beat_t;

	// Status of the datapath as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic out_full;
	} mac_status_t;

	// Index width for a store of n entries, never below one bit.
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// File: src/tctm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module tctm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/tctm_seq.sv
// Input decode, store write addressing, configuration and the burst sequencer.
module tctm_seq #(
	parameter int MAX_CHAN = 16,
	parameter int KERNEL = 4,
	parameter int WA_W = 12,
	parameter int TA_W = 8,
	parameter int BA_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,
	input  logic [1:0]                s_tuser,
	input  logic                      s_tlast,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [tctm_pkg::CFG_W-1:0] cfg_wdata,
	input  tctm_pkg::mac_status_t     status,
	output logic                      w_we,
	output logic [WA_W-1:0]           w_waddr,
	output logic [WA_W-1:0]           w_raddr,
	output logic                      t_we,
	output logic [TA_W-1:0]           t_waddr,
	output logic [TA_W-1:0]           t_raddr,
	output logic                      b_we,
	output logic [BA_W-1:0]           b_waddr,
	output logic [BA_W-1:0]           b_raddr,
	output logic                      rd_en,
	output tctm_pkg::beat_t           beat_s1
);
	import tctm_pkg::*;

	localparam int KK = KERNEL * KERNEL;
	localparam int CNT_W = $clog2(MAX_CHAN + 1);
	localparam int K_W = idx_w(KK);
	localparam int OUT_TOP = (MAX_CHAN < RESULT_LIMIT) ? MAX_CHAN : RESULT_LIMIT;

	logic [3:0] in_chan;
	logic [3:0] out_chan;
	logic [1:0] row;
	logic [1:0] col;
	logic       in_acc;
	logic       ic_ok;
	logic       oc_ok;
	logic       pos_ok;
	logic       trigger;

	logic [CFG_W-1:0] cfg_in_q;
	logic [CFG_W-1:0] cfg_out_q;
	logic [CNT_W-1:0] nin_clamp;
	logic [CNT_W-1:0] nout_clamp;

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [CNT_W-1:0] nin_q;
	logic [CNT_W-1:0] nout_q;
	logic [CNT_W-1:0] o_q;
	logic [CNT_W-1:0] i_q;
	logic [K_W-1:0]   k_q;

	logic issue;
	logic beat_first;
	logic beat_last;
	logic k_end;
	logic chan_end;

	// Field unpacking of the input word.
	assign in_chan  = s_tdata[3:0];
	assign out_chan = s_tdata[7:4];
	assign row      = s_tdata[9:8];
	assign col      = s_tdata[11:10];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign ic_ok    = 32'(in_chan) < MAX_CHAN;
	assign oc_ok    = 32'(out_chan) < MAX_CHAN;
	assign pos_ok   = (32'(row) < KERNEL) && (32'(col) < KERNEL);
	assign trigger  = in_acc && (s_tuser == OP_TILE) && s_tlast;

	// Store writes; the weight is placed with its window mirrored.
	assign w_we = in_acc && (s_tuser == OP_WEIGHT) && ic_ok && oc_ok && pos_ok;
	assign t_we = in_acc && (s_tuser == OP_TILE) && ic_ok && pos_ok;
	assign b_we = in_acc && (s_tuser == OP_BIAS) && oc_ok;
	assign w_waddr = WA_W'((32'(in_chan) * MAX_CHAN + 32'(out_chan)) * KK
		+ (KERNEL - 1 - 32'(row)) * KERNEL + (KERNEL - 1 - 32'(col)));
	assign t_waddr = TA_W'((32'(in_chan) * KERNEL + 32'(row)) * KERNEL + 32'(col));
	assign b_waddr = BA_W'(out_chan);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_in_q  <= CFG_W'(1);
			cfg_out_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_CHANNELS:  cfg_in_q <= cfg_wdata;
				REG_OUT_CHANNELS: cfg_out_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Channel counts clamped to the store size and the result limit.
	assign nin_clamp  = CNT_W'((32'(cfg_in_q) > MAX_CHAN) ? MAX_CHAN : 32'(cfg_in_q));
	assign nout_clamp = CNT_W'((32'(cfg_out_q) > OUT_TOP) ? OUT_TOP : 32'(cfg_out_q));

	// Read addressing of the current beat.
	assign w_raddr = WA_W'((32'(i_q) * MAX_CHAN + 32'(o_q)) * KK + 32'(k_q));
	assign t_raddr = TA_W'(32'(i_q) * KK + 32'(k_q));
	assign b_raddr = BA_W'(o_q);

	assign k_end      = (k_q == K_W'(KK - 1));
	assign beat_first = (i_q == '0) && (k_q == '0);
	assign beat_last  = (nin_q == '0) || (k_end && (CNT_W'(i_q + 1'b1) == nin_q));
	assign chan_end   = (CNT_W'(o_q + 1'b1) == nout_q);

	// Next state and beat issue.
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (trigger && (nout_clamp != '0)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!status.out_full) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (beat_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = chan_end ? ST_IDLE : ST_WAIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rd_en = issue;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop counters over output channel, input channel and window position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nin_q  <= '0;
			nout_q <= '0;
			o_q    <= '0;
			i_q    <= '0;
			k_q    <= '0;
		end else begin
			if (state_q == ST_IDLE && trigger) begin
				nin_q  <= nin_clamp;
				nout_q <= nout_clamp;
				o_q    <= '0;
				i_q    <= '0;
				k_q    <= '0;
			end else if (issue) begin
				if (beat_last) begin
					i_q <= '0;
					k_q <= '0;
				end else if (k_end) begin
					k_q <= '0;
					i_q <= CNT_W'(i_q + 1'b1);
				end else begin
					k_q <= K_W'(k_q + 1'b1);
				end
			end else if (state_q == ST_DRAIN && !status.busy && !chan_end) begin
				o_q <= CNT_W'(o_q + 1'b1);
			end
		end
	end

	// Beat descriptor, aligned with the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
		end else begin
			beat_s1.valid     <= issue;
			beat_s1.first     <= beat_first;
			beat_s1.last      <= beat_last;
			beat_s1.term      <= (nin_q != '0);
			beat_s1.last_chan <= chan_end;
			beat_s1.chan      <= CHAN_W'(o_q);
		end
	end

endmodule

// File: src/tctm_mac.sv
// Multiply-accumulate datapath with saturation and the result output register.
module tctm_mac #(
	parameter int MAX_CHAN = 16,
	parameter int KERNEL = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tctm_pkg::beat_t              beat_s1,
	input  logic [tctm_pkg::VALUE_W-1:0] w_rdata,
	input  logic [tctm_pkg::VALUE_W-1:0] t_rdata,
	input  logic [tctm_pkg::VALUE_W-1:0] b_rdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tctm_pkg::SUM_W-1:0]   m_tdata,
	output logic [tctm_pkg::CHAN_W-1:0]  m_tuser,
	output logic                         m_tlast,
	output tctm_pkg::mac_status_t        status
);
	import tctm_pkg::*;

	localparam int ACC_W = SUM_W + 1 + $clog2(MAX_CHAN * KERNEL * KERNEL + 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SUM_W){1'b0}}, 1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-SUM_W){1'b1}}, 1'b1, {(SUM_W-1){1'b0}}};

	beat_t                     beat_s2;
	logic signed [SUM_W-1:0]   prod_s2;
	logic [VALUE_W-1:0]        bias_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   acc_d;
	logic [SUM_W-1:0]          sat;
	logic                      out_valid_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CHAN_W-1:0]         chan_q;
	logic                      last_q;

	// Product stage.
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rdata) * $signed(t_rdata);
		bias_s2 <= b_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s2 <= '0;
		end else begin
			beat_s2 <= beat_s1;
		end
	end

	// Accumulate; the first beat of a channel starts from the aligned bias.
	assign base = beat_s2.first
		? {{(ACC_W-VALUE_W-FRAC_SHIFT){bias_s2[VALUE_W-1]}}, bias_s2, {FRAC_SHIFT{1'b0}}}
		: acc_q;
	assign addend = beat_s2.term ? {{(ACC_W-SUM_W){prod_s2[SUM_W-1]}}, prod_s2} : '0;
	assign acc_d  = base + addend;

	// Saturate once to the 32-bit result range.
	always_comb begin
		if (acc_d > SAT_HI) begin
			sat = SAT_HI[SUM_W-1:0];
		end else if (acc_d < SAT_LO) begin
			sat = SAT_LO[SUM_W-1:0];
		end else begin
			sat = acc_d[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (beat_s2.valid) begin
			acc_q <= acc_d;
		end
	end

	// Output register; the sequencer never lets a result arrive while it is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat_s2.valid && beat_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_s2.valid && beat_s2.last) begin
			sum_q  <= sat;
			chan_q <= beat_s2.chan;
			last_q <= beat_s2.last_chan;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sum_q;
	assign m_tuser  = chan_q;
	assign m_tlast  = last_q;

	assign status.busy     = beat_s1.valid || beat_s2.valid;
	assign status.out_full = out_valid_q;

endmodule

// File: src/transposed_conv_tile_mac_top.sv
// Top level of the transposed-convolution tile MAC.
//
// Weight, bias and tile words are taken one per cycle and written straight into
// their stores, weights with the kernel window mirrored. A tile word with tlast
// set starts a burst, unless no output channel is configured, during which no
// input word is taken. For each active output channel the sequencer waits for
// the output register to be free, then issues one beat per cycle, since one
// shared multiplier reads one weight and one tile sample per cycle from the
// single read ports of the weight and tile memories, then lets the pipeline
// drain; with no active input channel a single beat passes the bias alone. A
// result that the receiver holds back stalls the next channel until it is
// taken. Results come out in ascending channel order, the last one with tlast
// set; a new burst may start while the final result of the previous one still
// waits. The stores need no clearing pass after reset.
module transposed_conv_tile_mac_top #(
	parameter int MAX_CHAN = 16,
	parameter int KERNEL = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,   // in_chan, out_chan, row, col, value, zero pad
	input  logic [1:0]                s_tuser,   // operation
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,   // sum
	output logic [3:0]                m_tuser,   // channel
	output logic                      m_tlast,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [4:0]                cfg_wdata
);
	import tctm_pkg::*;

	localparam int KK = KERNEL * KERNEL;
	localparam int W_DEPTH = MAX_CHAN * MAX_CHAN * KK;
	localparam int T_DEPTH = MAX_CHAN * KK;
	localparam int WA_W = idx_w(W_DEPTH);
	localparam int TA_W = idx_w(T_DEPTH);
	localparam int BA_W = idx_w(MAX_CHAN);

	logic               w_we;
	logic [WA_W-1:0]    w_waddr;
	logic [WA_W-1:0]    w_raddr;
	logic               t_we;
	logic [TA_W-1:0]    t_waddr;
	logic [TA_W-1:0]    t_raddr;
	logic               b_we;
	logic [BA_W-1:0]    b_waddr;
	logic [BA_W-1:0]    b_raddr;
	logic               rd_en;
	logic [VALUE_W-1:0] w_rdata;
	logic [VALUE_W-1:0] t_rdata;
	logic [VALUE_W-1:0] b_rdata;
	logic [VALUE_W-1:0] value;
	beat_t              beat_s1;
	mac_status_t        status;

	assign value = s_tdata[27:12];

	// Sequencer and input decode.
	tctm_seq #(
		.MAX_CHAN(MAX_CHAN),
		.KERNEL  (KERNEL),
		.WA_W    (WA_W),
		.TA_W    (TA_W),
		.BA_W    (BA_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.status   (status),
		.w_we     (w_we),
		.w_waddr  (w_waddr),
		.w_raddr  (w_raddr),
		.t_we     (t_we),
		.t_waddr  (t_waddr),
		.t_raddr  (t_raddr),
		.b_we     (b_we),
		.b_waddr  (b_waddr),
		.b_raddr  (b_raddr),
		.rd_en    (rd_en),
		.beat_s1  (beat_s1)
	);

	// Weight store.
	tctm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(W_DEPTH)
	) u_weight_ram (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_waddr),
		.wdata(value),
		.re   (rd_en),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	// Tile store.
	tctm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(T_DEPTH)
	) u_tile_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(value),
		.re   (rd_en),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	// Bias store.
	tctm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_CHAN)
	) u_bias_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(value),
		.re   (rd_en),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	// Multiply-accumulate datapath and output register.
	tctm_mac #(
		.MAX_CHAN(MAX_CHAN),
		.KERNEL  (KERNEL)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.w_rdata (w_rdata),
		.t_rdata (t_rdata),
		.b_rdata (b_rdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.status  (status)
	);

endmodule

// File: src/tctm_checker.sv
// Port-level checks of the transposed-convolution tile MAC, bound to the top level.
module tctm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [4:0]  cfg_wdata
);

	logic [3:0] exp_chan_q;

	// Channel expected on the next result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_chan_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_chan_q <= m_tlast ? 4'd0 : 4'(exp_chan_q + 1'b1);
		end
	end

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	// Results of a burst come in ascending channel order from channel zero.
	a_chan_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == exp_chan_q)
		else $error("result channel out of order");

	// While a burst still has channels to deliver, no input word is taken.
	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken in the middle of a result burst");

	// Nothing is shown on the output straight out of reset.
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result word valid after reset");

endmodule

bind transposed_conv_tile_mac_top tctm_checker u_tctm_checker (.*);
